@@ hdl/ign3_pkg.sv @@
// Shared constants for the 3D gradient noise unit.
// No dependencies; used by ign3_perm_ram and improved_gradient_noise_3d_unit.
`default_nettype none
package ign3_pkg;
    localparam int PERM_ENTRIES = 256;
    localparam int PERM_AW      = $clog2(PERM_ENTRIES);
    localparam int PERM_DW      = 8;
    localparam int FRAC_BITS    = 16;
    localparam int COORD_FRAC   = 16;
    localparam int OUT_MIN      = -131072;
    localparam int OUT_MAX      = 131071;
    localparam int NUM_CFG      = 3;
    localparam int CFG_IW       = 2;
    localparam int CFG_DW       = 24;

    typedef enum logic [CFG_IW-1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2
    } t_cfg_idx;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
endpackage
`default_nettype wire

@@ hdl/ign3_perm_ram.sv @@
// One copy of the permutation table: one write port, two registered read ports.
// Depends on ign3_pkg for the default depth and width.
`default_nettype none
module ign3_perm_ram #(
    parameter int DEPTH = ign3_pkg::PERM_ENTRIES,
    parameter int DW    = ign3_pkg::PERM_DW
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [DW-1:0]            o_rdata_a,
    output logic      [DW-1:0]            o_rdata_b
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

@@ hdl/improved_gradient_noise_3d_unit.sv @@
// Top level of the 3D improved gradient noise unit: pipeline, table copies, config.
// Depends on ign3_pkg and ign3_perm_ram.
//
// channel   | dir | handshake                     | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready   | tuser=req_type, tdata=index,value,x,y,z
// m_axis    | out | m_axis_tvalid/m_axis_tready   | tdata=noise_value
// cfg       | in  | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; a query passes through stage
// registers 1-9, then the output register, before m_axis_tvalid rises. At most one
// multiply deep per stage. Table loads write each of the seven table copies at the
// stage that reads it. A stalled output freezes the whole pipeline; reset empties
// it, clears offsets and holds s_axis_tready low.
`default_nettype none
module improved_gradient_noise_3d_unit #(
    parameter int FRAC_BITS = ign3_pkg::FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] entry_index, [15:8] entry_value, [47:16] coord_x, [79:48] coord_y,
    // [111:80] coord_z
    input  wire logic [111:0]                    s_axis_tdata,
    // [0] req_type
    input  wire logic [0:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [17:0] noise_value, [23:18] zero
    output logic [23:0]                          m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [ign3_pkg::CFG_IW-1:0]     i_cfg_index,
    input  wire logic [ign3_pkg::CFG_DW-1:0]     i_cfg_data
);
    localparam int W   = FRAC_BITS + 6;
    localparam int PW  = 2 * W;
    localparam int XW  = W + 8;
    localparam int SHR = (FRAC_BITS >= ign3_pkg::COORD_FRAC) ?
                         FRAC_BITS - ign3_pkg::COORD_FRAC : 0;
    localparam int SHL = (FRAC_BITS < ign3_pkg::COORD_FRAC) ?
                         ign3_pkg::COORD_FRAC - FRAC_BITS : 0;
    localparam int AW  = ign3_pkg::PERM_AW;
    localparam int DW  = ign3_pkg::PERM_DW;
    localparam int NR  = 7;

    typedef logic signed [W-1:0]  t_val;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [XW-1:0] t_ext;

    localparam t_val ONE = t_val'(longint'(1) <<< FRAC_BITS);
    localparam t_val C15 = t_val'(longint'(15) <<< FRAC_BITS);
    localparam t_val C10 = t_val'(longint'(10) <<< FRAC_BITS);

    function automatic t_prod mul(input t_val a, input t_val b);
        return t_prod'(a) * t_prod'(b);
    endfunction

    function automatic t_val sdn(input t_prod p);
        t_prod s;
        s = p >>> FRAC_BITS;
        return s[W-1:0];
    endfunction

    function automatic t_val grad(input logic [DW-1:0] hh, input t_val x, input t_val y,
                                  input t_val z);
        logic [3:0] h;
        t_val       u, v, su, sv;
        h  = hh[3:0];
        u  = (h < 4'd8) ? x : y;
        v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        su = h[0] ? -u : u;
        sv = h[1] ? -v : v;
        return su + sv;
    endfunction

    // config
    logic [ign3_pkg::CFG_DW-1:0] r_offset [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_offset[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ign3_pkg::CFG_OFFSET_X: r_offset[0] <= i_cfg_data;
                ign3_pkg::CFG_OFFSET_Y: r_offset[1] <= i_cfg_data;
                ign3_pkg::CFG_OFFSET_Z: r_offset[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;

    // stage valid / query flags
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_q1, r_q2, r_q3, r_q4, r_q5, r_q6, r_q7, r_q8, r_q9;

    // stage payload
    logic [AW-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [DW-1:0] r_s1_val, r_s2_val, r_s3_val, r_s4_val;
    logic [31:0]   r_s1_coord [3];
    logic [7:0]    r_s2_cell  [3];
    logic [7:0]    r_s3_cy, r_s3_cz, r_s4_cz;
    t_val          r_s2_frac [3], r_s3_frac [3], r_s4_frac [3], r_s5_frac [3];
    t_prod         r_s3_p [3], r_s4_p [3], r_s5_p [3], r_s6_p [3];
    t_val          r_s6_g [8];
    t_val          r_s7_a [4];
    t_prod         r_s7_pr [4];
    t_val          r_s7_ev, r_s7_ew, r_s8_ew;
    t_val          r_s8_a [2];
    t_prod         r_s8_pr [2];
    t_val          r_s9_a;
    t_prod         r_s9_pr;
    logic [17:0]   r_out;

    // table copies
    logic          ram_we [NR];
    logic [AW-1:0] ram_wa [NR], ram_ra [NR], ram_rb [NR];
    logic [DW-1:0] ram_wd [NR], ram_da [NR], ram_db [NR];

    genvar gk;
    generate
        for (gk = 0; gk < NR; gk++) begin : g_ram
            ign3_perm_ram #(.DEPTH(ign3_pkg::PERM_ENTRIES), .DW(DW)) u_ram (
                .i_clk     (i_clk),
                .i_en      (en),
                .i_we      (ram_we[gk]),
                .i_waddr   (ram_wa[gk]),
                .i_wdata   (ram_wd[gk]),
                .i_raddr_a (ram_ra[gk]),
                .i_raddr_b (ram_rb[gk]),
                .o_rdata_a (ram_da[gk]),
                .o_rdata_b (ram_db[gk])
            );
        end
    endgenerate

    // stage combinational logic
    logic [23:0]   sum24 [3];
    logic [39:0]   fext  [3];
    logic [7:0]    n_cell [3];
    t_val          n_frac [3];
    t_prod         n_p2 [3], n_p3 [3], n_p4 [3], n_p5 [3];
    logic [7:0]    pa, pb, aa, ab, ba, bb;
    t_val          x1, y1, z1;
    t_val          n_g [8];
    t_val          e [3];
    t_prod         n_pr6 [4];
    t_val          rr [4];
    t_prod         n_pr7 [2];
    t_val          ss [2];
    t_prod         n_pr8;
    t_val          res;
    t_ext          res_x, res_s;
    logic [17:0]   n_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum24[i]  = r_s1_coord[i][23:0] + r_offset[i];
            n_cell[i] = sum24[i][23:16];
            fext[i]   = {sum24[i][15:0], 24'd0};
            n_frac[i] = t_val'({1'b0, fext[i][39 -: FRAC_BITS]});
            n_p2[i]   = mul(r_s2_frac[i], (r_s2_frac[i] <<< 2) + (r_s2_frac[i] <<< 1) - C15);
            n_p3[i]   = mul(r_s3_frac[i], sdn(r_s3_p[i]) + C10);
            n_p4[i]   = mul(r_s4_frac[i], sdn(r_s4_p[i]));
            n_p5[i]   = mul(r_s5_frac[i], sdn(r_s5_p[i]));
            e[i]      = sdn(r_s6_p[i]);
            if (e[i] < 0) begin
                e[i] = '0;
            end
            if (e[i] > ONE) begin
                e[i] = ONE;
            end
        end
        pa = ram_da[0] + r_s3_cy;
        pb = ram_db[0] + r_s3_cy;
        aa = ram_da[1] + r_s4_cz;
        ab = ram_db[1] + r_s4_cz;
        ba = ram_da[2] + r_s4_cz;
        bb = ram_db[2] + r_s4_cz;

        x1 = r_s5_frac[0] - ONE;
        y1 = r_s5_frac[1] - ONE;
        z1 = r_s5_frac[2] - ONE;
        n_g[0] = grad(ram_da[3], r_s5_frac[0], r_s5_frac[1], r_s5_frac[2]);
        n_g[1] = grad(ram_da[5], x1,           r_s5_frac[1], r_s5_frac[2]);
        n_g[2] = grad(ram_da[4], r_s5_frac[0], y1,           r_s5_frac[2]);
        n_g[3] = grad(ram_da[6], x1,           y1,           r_s5_frac[2]);
        n_g[4] = grad(ram_db[3], r_s5_frac[0], r_s5_frac[1], z1);
        n_g[5] = grad(ram_db[5], x1,           r_s5_frac[1], z1);
        n_g[6] = grad(ram_db[4], r_s5_frac[0], y1,           z1);
        n_g[7] = grad(ram_db[6], x1,           y1,           z1);

        for (int k = 0; k < 4; k++) begin
            n_pr6[k] = mul(e[0], r_s6_g[2*k+1] - r_s6_g[2*k]);
            rr[k]    = r_s7_a[k] + sdn(r_s7_pr[k]);
        end
        n_pr7[0] = mul(r_s7_ev, rr[1] - rr[0]);
        n_pr7[1] = mul(r_s7_ev, rr[3] - rr[2]);
        for (int k = 0; k < 2; k++) begin
            ss[k] = r_s8_a[k] + sdn(r_s8_pr[k]);
        end
        n_pr8 = mul(r_s8_ew, ss[1] - ss[0]);

        res   = r_s9_a + sdn(r_s9_pr);
        res_x = t_ext'(res);
        res_s = (res_x >>> SHR) <<< SHL;
        if (res_s < t_ext'(ign3_pkg::OUT_MIN)) begin
            n_out = 18'(ign3_pkg::OUT_MIN);
        end else if (res_s > t_ext'(ign3_pkg::OUT_MAX)) begin
            n_out = 18'(ign3_pkg::OUT_MAX);
        end else begin
            n_out = res_s[17:0];
        end
    end

    // table port hookup: copy 0 at stage 2, copies 1-2 at stage 3, 3-6 at stage 4
    always_comb begin
        ram_we[0] = en && r_v2 && (r_q2 == ign3_pkg::REQ_LOAD);
        ram_wa[0] = r_s2_idx;
        ram_wd[0] = r_s2_val;
        ram_ra[0] = r_s2_cell[0];
        ram_rb[0] = r_s2_cell[0] + 8'd1;
        for (int k = 1; k < 3; k++) begin
            ram_we[k] = en && r_v3 && (r_q3 == ign3_pkg::REQ_LOAD);
            ram_wa[k] = r_s3_idx;
            ram_wd[k] = r_s3_val;
        end
        for (int k = 3; k < NR; k++) begin
            ram_we[k] = en && r_v4 && (r_q4 == ign3_pkg::REQ_LOAD);
            ram_wa[k] = r_s4_idx;
            ram_wd[k] = r_s4_val;
        end
        ram_ra[1] = pa;
        ram_rb[1] = pa + 8'd1;
        ram_ra[2] = pb;
        ram_rb[2] = pb + 8'd1;
        ram_ra[3] = aa;
        ram_rb[3] = aa + 8'd1;
        ram_ra[4] = ab;
        ram_rb[4] = ab + 8'd1;
        ram_ra[5] = ba;
        ram_rb[5] = ba + 8'd1;
        ram_ra[6] = bb;
        ram_rb[6] = bb + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
            r_v6 <= r_v5; r_v7 <= r_v6; r_v8 <= r_v7; r_v9 <= r_v8;
            m_axis_tvalid <= r_v9 && (r_q9 == ign3_pkg::REQ_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1 <= s_axis_tuser[0];
            r_q2 <= r_q1; r_q3 <= r_q2; r_q4 <= r_q3; r_q5 <= r_q4;
            r_q6 <= r_q5; r_q7 <= r_q6; r_q8 <= r_q7; r_q9 <= r_q8;

            r_s1_idx      <= s_axis_tdata[7:0];
            r_s1_val      <= s_axis_tdata[15:8];
            r_s1_coord[0] <= s_axis_tdata[47:16];
            r_s1_coord[1] <= s_axis_tdata[79:48];
            r_s1_coord[2] <= s_axis_tdata[111:80];

            r_s2_idx <= r_s1_idx; r_s2_val <= r_s1_val;
            r_s3_idx <= r_s2_idx; r_s3_val <= r_s2_val;
            r_s4_idx <= r_s3_idx; r_s4_val <= r_s3_val;

            r_s3_cy <= r_s2_cell[1];
            r_s3_cz <= r_s2_cell[2];
            r_s4_cz <= r_s3_cz;
            for (int i = 0; i < 3; i++) begin
                r_s2_cell[i] <= n_cell[i];
                r_s2_frac[i] <= n_frac[i];
                r_s3_frac[i] <= r_s2_frac[i];
                r_s4_frac[i] <= r_s3_frac[i];
                r_s5_frac[i] <= r_s4_frac[i];
                r_s3_p[i]    <= n_p2[i];
                r_s4_p[i]    <= n_p3[i];
                r_s5_p[i]    <= n_p4[i];
                r_s6_p[i]    <= n_p5[i];
            end
            for (int k = 0; k < 8; k++) begin
                r_s6_g[k] <= n_g[k];
            end
            for (int k = 0; k < 4; k++) begin
                r_s7_a[k]  <= r_s6_g[2*k];
                r_s7_pr[k] <= n_pr6[k];
            end
            r_s7_ev   <= e[1];
            r_s7_ew   <= e[2];
            r_s8_ew   <= r_s7_ew;
            r_s8_a[0] <= rr[0];
            r_s8_a[1] <= rr[2];
            r_s8_pr[0] <= n_pr7[0];
            r_s8_pr[1] <= n_pr7[1];
            r_s9_a    <= ss[0];
            r_s9_pr   <= n_pr8;
            r_out     <= n_out;
        end
    end

    assign m_axis_tdata = {6'd0, r_out};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !r_v1 && !r_v9)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v5) && $stable(r_q5) && $stable(r_s6_g[0]))
        else $error("pipeline moved during stall");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v9 && (r_q9 == ign3_pkg::REQ_LOAD)) |=> !m_axis_tvalid)
        else $error("load item produced a result");

    a_stall_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !ram_we[0] && !ram_we[1] && !ram_we[NR-1])
        else $error("table written during stall");
endmodule
`default_nettype wire
